@@ hdl/fflpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fflpa_pkg: shared types and constants of the page allocator
// Field widths, operation and status codes, shared adder op and ring controls.
// ----------------------------------------------------------------------------
package fflpa_pkg;

    localparam int POOL_PAGES_DEF   = 1024;
    localparam int MAX_BLOCKS_LIMIT = 64;

    localparam int OP_W     = 2;
    localparam int BLK_W    = 7;
    localparam int PAGE_W   = 10;
    localparam int STATUS_W = 3;
    localparam int FREE_W   = 11;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;
    localparam int M_PAD_W  = M_DATA_W - PAGE_W - FREE_W;

    localparam logic [BLK_W-1:0] MAX_CFG_RESET = 7'd64;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_APPEND = 2'd1,
        OP_FREE   = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_GRANTED    = 3'd0,
        STS_DONE       = 3'd1,
        STS_ALREADY    = 3'd2,
        STS_OVER_LIMIT = 3'd3,
        STS_SHORT      = 3'd4,
        STS_IGNORED    = 3'd5
    } status_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic rd_head;
        logic adv_head;
        logic push;
        logic map_rd;
        logic map_set;
        logic map_clr;
    } ring_ctrl_t;

endpackage

@@ hdl/fflpa_alu.sv @@
// ----------------------------------------------------------------------------
// fflpa_alu: shared add / compare unit
// One carry adder serves sums and less-than compares of the sequencer.
// ----------------------------------------------------------------------------
module fflpa_alu #(
    parameter int W = 8
) (
    input  fflpa_pkg::alu_op_t op,
    input  logic [W-1:0]       a,
    input  logic [W-1:0]       b,
    output logic [W-1:0]       res,
    output logic               lt
);
    import fflpa_pkg::*;

    logic         is_sub;
    logic [W-1:0] b_x;
    logic [W:0]   full;

    assign is_sub = (op == ALU_SUB);
    assign b_x    = is_sub ? ~b : b;
    assign full   = {1'b0, a} + {1'b0, b_x} + {{W{1'b0}}, is_sub};
    assign res    = full[W-1:0];
    // no carry out of a - b means a borrow
    assign lt     = is_sub && !full[W];

endmodule

@@ hdl/fflpa_ring.sv @@
// ----------------------------------------------------------------------------
// fflpa_ring: free ring memory, in-use map and their pointers
// Ring entries not yet written read as their own index; the map is
// cleared by a sweep after reset.
// ----------------------------------------------------------------------------
module fflpa_ring #(
    parameter int POOL_PAGES = fflpa_pkg::POOL_PAGES_DEF,
    localparam int IDX_W = $clog2(POOL_PAGES),
    localparam int CNT_W = $clog2(POOL_PAGES + 1)
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  fflpa_pkg::ring_ctrl_t  ctrl,
    input  logic [IDX_W-1:0]       map_addr,
    input  logic [IDX_W-1:0]       push_page,
    output logic [IDX_W-1:0]       head_page,
    output logic                   map_bit,
    output logic                   init_done
);
    import fflpa_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_PAGES - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(POOL_PAGES);

    logic [IDX_W-1:0] ring_mem [POOL_PAGES];
    logic             map_mem  [POOL_PAGES];

    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] tail_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             clr_busy_reg;
    logic [IDX_W-1:0] clr_addr_reg;

    logic [IDX_W-1:0] rd_data_reg;
    logic [IDX_W-1:0] rd_snap_reg;
    logic             rd_hit_reg;
    logic             map_q_reg;

    logic             map_we;
    logic [IDX_W-1:0] map_wa;
    logic             map_wd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            tail_reg     <= '0;
            fill_reg     <= '0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            if (ctrl.adv_head) begin
                head_reg <= (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);
            end
            if (ctrl.push) begin
                tail_reg <= (tail_reg == LAST_IDX) ? '0 : tail_reg + IDX_W'(1);
                // written entries are always a prefix of the ring
                if (fill_reg != FULL_CNT) begin
                    fill_reg <= fill_reg + CNT_W'(1);
                end
            end
            if (clr_busy_reg) begin
                if (clr_addr_reg == LAST_IDX) begin
                    clr_busy_reg <= 1'b0;
                end else begin
                    clr_addr_reg <= clr_addr_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            ring_mem[tail_reg] <= push_page;
        end
        if (ctrl.rd_head) begin
            rd_data_reg <= ring_mem[head_reg];
            rd_snap_reg <= head_reg;
            rd_hit_reg  <= (CNT_W'(head_reg) < fill_reg);
        end
    end

    assign map_we = clr_busy_reg || ctrl.map_set || ctrl.map_clr;
    assign map_wa = clr_busy_reg ? clr_addr_reg : map_addr;
    assign map_wd = !clr_busy_reg && ctrl.map_set;

    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_wa] <= map_wd;
        end
        if (ctrl.map_rd) begin
            map_q_reg <= map_mem[map_addr];
        end
    end

    assign head_page = rd_hit_reg ? rd_data_reg : rd_snap_reg;
    assign map_bit   = map_q_reg;
    assign init_done = !clr_busy_reg;

endmodule

@@ hdl/fifo_free_list_page_allocator.sv @@
// ----------------------------------------------------------------------------
// fifo_free_list_page_allocator: page pool with a FIFO free ring
// Grants pages from the ring head, takes freed pages back at the tail.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes one request: the operation in s_tuser, the counts and
//   the page id in s_tdata. m_ channel returns results: the granted page and
//   the free count in m_tdata, the status in m_tuser, m_tlast on the last
//   result of a request. cfg_we writes the per-sequence page limit.
//   Requests are handled one at a time through a small sequencer that runs
//   the checks on one shared adder/comparator. An allocate or append that
//   passes the sum, limit and pool checks hands out its pages one by one,
//   each after one ring memory read. A free reads the in-use map once
//   before it answers; a rejected request answers via S_REPLY.
//   The output register lets the next request in while a result waits; a
//   stalled m_tready holds the sequencer before its next result.
//   After reset the in-use map is swept clear with s_tready low;
//   configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module fifo_free_list_page_allocator #(
    parameter int POOL_PAGES = fflpa_pkg::POOL_PAGES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [fflpa_pkg::BLK_W-1:0]     cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // block_count, existing_blocks, free_page_id
    input  logic [fflpa_pkg::S_DATA_W-1:0]  s_tdata,
    // operation
    input  logic [fflpa_pkg::OP_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // granted_page, free_pages_left, zero pad
    output logic [fflpa_pkg::M_DATA_W-1:0]  m_tdata,
    // status
    output logic [fflpa_pkg::STATUS_W-1:0]  m_tuser,
    output logic                            m_tlast
);
    import fflpa_pkg::*;

    localparam int IDX_W = $clog2(POOL_PAGES);
    localparam int CNT_W = $clog2(POOL_PAGES + 1);
    localparam int ALU_W = (CNT_W > BLK_W + 1) ? CNT_W : BLK_W + 1;

    typedef enum logic [9:0] {
        S_INIT  = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_SUM   = 10'b0000000100,
        S_LIMIT = 10'b0000001000,
        S_POOL  = 10'b0000010000,
        S_RD    = 10'b0000100000,
        S_GRANT = 10'b0001000000,
        S_FRD   = 10'b0010000000,
        S_FCHK  = 10'b0100000000,
        S_REPLY = 10'b1000000000
    } state_t;

    state_t             state_reg, state_next;
    logic [BLK_W-1:0]   cfg_max_reg;
    logic [BLK_W-1:0]   count_reg;
    logic [BLK_W-1:0]   existing_reg;
    logic [PAGE_W-1:0]  page_reg;
    logic               page_ok_reg;
    logic [ALU_W-1:0]   sum_reg, sum_next;
    logic [BLK_W-1:0]   remain_reg, remain_next;
    status_t            reply_reg, reply_next;
    logic [CNT_W-1:0]   free_total_reg, free_next;

    logic               m_tvalid_reg;
    logic [PAGE_W-1:0]  m_page_reg;
    logic [FREE_W-1:0]  m_free_reg;
    status_t            m_status_reg;
    logic               m_last_reg;

    op_t                in_op;
    logic [BLK_W-1:0]   in_count;
    logic [BLK_W-1:0]   in_existing;
    logic [PAGE_W-1:0]  in_page;
    logic               accept;
    logic               out_free;
    logic [BLK_W-1:0]   limit;

    alu_op_t            alu_op;
    logic [ALU_W-1:0]   alu_a, alu_b, alu_res;
    logic               alu_lt;

    ring_ctrl_t         ctrl;
    logic [IDX_W-1:0]   map_addr;
    logic [IDX_W-1:0]   page_idx;
    logic [IDX_W-1:0]   head_page;
    logic               map_bit;
    logic               ring_ready;
    logic [31:0]        page_wide;
    logic [31:0]        head_wide;
    logic [31:0]        free_wide;

    logic               emit;
    logic               e_last;
    logic [PAGE_W-1:0]  e_page;
    status_t            e_status;

    assign in_op       = op_t'(s_tuser);
    assign in_count    = s_tdata[BLK_W-1:0];
    assign in_existing = s_tdata[2*BLK_W-1:BLK_W];
    assign in_page     = s_tdata[2*BLK_W+PAGE_W-1:2*BLK_W];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // register values above the supported range act as the range top
    assign limit = (cfg_max_reg > BLK_W'(MAX_BLOCKS_LIMIT)) ? BLK_W'(MAX_BLOCKS_LIMIT)
                                                             : cfg_max_reg;

    assign page_wide = 32'(page_reg);
    assign page_idx  = page_wide[IDX_W-1:0];
    assign head_wide = 32'(head_page);
    assign free_wide = 32'(free_next);

    fflpa_alu #(
        .W (ALU_W)
    ) u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res),
        .lt  (alu_lt)
    );

    fflpa_ring #(
        .POOL_PAGES (POOL_PAGES)
    ) u_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .map_addr  (map_addr),
        .push_page (page_idx),
        .head_page (head_page),
        .map_bit   (map_bit),
        .init_done (ring_ready)
    );

    always_comb begin
        state_next  = state_reg;
        sum_next    = sum_reg;
        remain_next = remain_reg;
        reply_next  = reply_reg;
        free_next   = free_total_reg;
        ctrl        = '0;
        map_addr    = page_idx;
        alu_op      = ALU_ADD;
        alu_a       = '0;
        alu_b       = '0;
        emit        = 1'b0;
        e_last      = 1'b1;
        e_page      = '0;
        e_status    = STS_DONE;

        unique case (state_reg)
            S_INIT: begin
                if (ring_ready) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    unique case (in_op)
                        OP_ALLOC: begin
                            if (in_existing != '0) begin
                                reply_next = STS_ALREADY;
                                state_next = S_REPLY;
                            end else begin
                                state_next = S_SUM;
                            end
                        end
                        OP_APPEND: begin
                            if (in_count == '0) begin
                                reply_next = STS_DONE;
                                state_next = S_REPLY;
                            end else begin
                                state_next = S_SUM;
                            end
                        end
                        OP_FREE: begin
                            state_next = S_FRD;
                        end
                        default: begin
                            reply_next = STS_IGNORED;
                            state_next = S_REPLY;
                        end
                    endcase
                end
            end
            S_SUM: begin
                alu_op     = ALU_ADD;
                alu_a      = ALU_W'(existing_reg);
                alu_b      = ALU_W'(count_reg);
                sum_next   = alu_res;
                state_next = S_LIMIT;
            end
            S_LIMIT: begin
                alu_op = ALU_SUB;
                alu_a  = ALU_W'(limit);
                alu_b  = sum_reg;
                if (alu_lt) begin
                    reply_next = STS_OVER_LIMIT;
                    state_next = S_REPLY;
                end else begin
                    state_next = S_POOL;
                end
            end
            S_POOL: begin
                alu_op = ALU_SUB;
                alu_a  = ALU_W'(free_total_reg);
                alu_b  = ALU_W'(count_reg);
                if (alu_lt) begin
                    reply_next = STS_SHORT;
                    state_next = S_REPLY;
                end else if (count_reg == '0) begin
                    reply_next = STS_DONE;
                    state_next = S_REPLY;
                end else begin
                    remain_next = count_reg;
                    state_next  = S_RD;
                end
            end
            S_RD: begin
                ctrl.rd_head = 1'b1;
                state_next   = S_GRANT;
            end
            S_GRANT: begin
                map_addr = head_page;
                if (out_free) begin
                    emit          = 1'b1;
                    e_page        = head_wide[PAGE_W-1:0];
                    e_status      = STS_GRANTED;
                    e_last        = (remain_reg == BLK_W'(1));
                    free_next     = free_total_reg - CNT_W'(1);
                    ctrl.adv_head = 1'b1;
                    ctrl.map_set  = 1'b1;
                    remain_next   = remain_reg - BLK_W'(1);
                    state_next    = e_last ? S_IDLE : S_RD;
                end
            end
            S_FRD: begin
                ctrl.map_rd = 1'b1;
                state_next  = S_FCHK;
            end
            S_FCHK: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (page_ok_reg && map_bit) begin
                        ctrl.push    = 1'b1;
                        ctrl.map_clr = 1'b1;
                        free_next    = free_total_reg + CNT_W'(1);
                        e_status     = STS_DONE;
                    end else begin
                        e_status = STS_IGNORED;
                    end
                    state_next = S_IDLE;
                end
            end
            S_REPLY: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_status   = reply_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_INIT;
            cfg_max_reg    <= MAX_CFG_RESET;
            free_total_reg <= CNT_W'(POOL_PAGES);
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            free_total_reg <= free_next;
            if (cfg_we) begin
                cfg_max_reg <= cfg_wdata;
            end
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg    <= sum_next;
        remain_reg <= remain_next;
        reply_reg  <= reply_next;
        if (accept) begin
            count_reg    <= in_count;
            existing_reg <= in_existing;
            page_reg     <= in_page;
            page_ok_reg  <= (32'(in_page) < 32'(POOL_PAGES));
        end
        if (emit) begin
            m_page_reg   <= e_page;
            m_free_reg   <= free_wide[FREE_W-1:0];
            m_status_reg <= e_status;
            m_last_reg   <= e_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, m_free_reg, m_page_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

`ifndef NO_ASSERTIONS
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_total_reg <= CNT_W'(POOL_PAGES))
        else $error("free page count above pool size");

    a_grant_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_GRANT) && out_free |=>
            free_total_reg == $past(free_total_reg) - CNT_W'(1))
        else $error("granted page did not lower the free count");

    a_grant_remain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_GRANT) |-> (remain_reg != '0))
        else $error("grant with no pages left to hand out");
`endif

endmodule

@@ tb/sv/fifo_free_list_page_allocator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_free_list_page_allocator_tb: self-checking bench for the page allocator
// Drives allocate, append and free requests with random gaps on both sides, gaps off in the last phase.
// A shadow of the free ring and in-use map predicts each result, and every
// result is checked field by field in order. The limit register is changed
// between phases while the block is idle.
// ----------------------------------------------------------------------------
module fifo_free_list_page_allocator_tb;
    import fflpa_pkg::*;

    localparam int N_PAGES    = POOL_PAGES_DEF;
    localparam int QUIET_MAX  = 5000;
    localparam int PHASE_REQS = 15;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [PAGE_W-1:0] page;
        status_t           status;
        logic              last;
        logic [FREE_W-1:0] left;
    } page_result_t;

    // shadow of the pool, fed with every accepted request
    class page_pool_shadow;
        int                ring[N_PAGES];
        bit                in_use[N_PAGES];
        int                head;
        int                tail;
        int                free_total;
        int                max_blocks;
        int                errors;
        page_result_t      awaited_results[$];
        int                held_pages[$];

        function new();
            for (int i = 0; i < N_PAGES; i++) begin
                ring[i]   = i;
                in_use[i] = 1'b0;
            end
            head       = 0;
            tail       = 0;
            free_total = N_PAGES;
            max_blocks = MAX_CFG_RESET;
            errors     = 0;
        endfunction

        function int limit();
            return (max_blocks > MAX_BLOCKS_LIMIT) ? MAX_BLOCKS_LIMIT : max_blocks;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        function void add_result(int page, status_t status, logic last);
            page_result_t r;
            r.page   = PAGE_W'(page);
            r.status = status;
            r.last   = last;
            r.left   = FREE_W'(free_total);
            awaited_results.insert(awaited_results.size(), r);
        endfunction

        function void grant_pages(int n);
            int page;
            if (n == 0) begin
                add_result(0, STS_DONE, 1'b1);
                return;
            end
            for (int i = 0; i < n; i++) begin
                page = ring[head];
                head = (head + 1) % N_PAGES;
                free_total--;
                in_use[page] = 1'b1;
                held_pages.insert(held_pages.size(), page);
                add_result(page, STS_GRANTED, i == n - 1);
            end
        endfunction

        function void take_request(logic [OP_W-1:0] op, logic [BLK_W-1:0] count,
                                   logic [BLK_W-1:0] existing, logic [PAGE_W-1:0] page);
            int lim;
            int idx[$];
            lim = limit();
            case (op)
                OP_ALLOC: begin
                    if (existing != 0)
                        add_result(0, STS_ALREADY, 1'b1);
                    else if (count > lim)
                        add_result(0, STS_OVER_LIMIT, 1'b1);
                    else if (free_total < count)
                        add_result(0, STS_SHORT, 1'b1);
                    else
                        grant_pages(count);
                end
                OP_APPEND: begin
                    // sum taken in int, so it never wraps
                    if (count == 0)
                        add_result(0, STS_DONE, 1'b1);
                    else if (int'(existing) + int'(count) > lim)
                        add_result(0, STS_OVER_LIMIT, 1'b1);
                    else if (free_total < count)
                        add_result(0, STS_SHORT, 1'b1);
                    else
                        grant_pages(count);
                end
                OP_FREE: begin
                    if (page >= N_PAGES || !in_use[page]) begin
                        add_result(0, STS_IGNORED, 1'b1);
                    end else begin
                        in_use[page] = 1'b0;
                        ring[tail]   = page;
                        tail         = (tail + 1) % N_PAGES;
                        free_total++;
                        idx = held_pages.find_first_index(x) with (x == page);
                        if (idx.size() != 0)
                            held_pages.delete(idx[0]);
                        add_result(0, STS_DONE, 1'b1);
                    end
                end
                default: begin
                    add_result(0, STS_IGNORED, 1'b1);
                end
            endcase
        endfunction

        function void check_result(logic [PAGE_W-1:0] page, logic [STATUS_W-1:0] status,
                                   logic last, logic [FREE_W-1:0] left);
            page_result_t want;
            if (awaited_results.size() == 0) begin
                $error("result with nothing awaited: status %0d page %0d", status, page);
                errors++;
                return;
            end
            want = awaited_results[0];
            awaited_results.delete(0);
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                errors++;
            end
            if (page !== want.page) begin
                $error("granted_page: expected %0d, got %0d", want.page, page);
                errors++;
            end
            if (last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, last);
                errors++;
            end
            if (left !== want.left) begin
                $error("free_pages_left: expected %0d, got %0d", want.left, left);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [BLK_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic [OP_W-1:0]       s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  m_tlast;

    page_pool_shadow pool = new();
    bit              gaps_on = 1'b1;

    fifo_free_list_page_allocator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // result side: random stall bursts, check every accepted result
    always @(posedge aclk) begin
        int stall_left;
        if (aresetn && m_tvalid && m_tready)
            pool.check_result(m_tdata[PAGE_W-1:0], m_tuser, m_tlast,
                              m_tdata[PAGE_W +: FREE_W]);
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 5) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_MAX) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("fifo_free_list_page_allocator_tb: done, errors");
        $finish;
    end

    task automatic send_request(input logic [OP_W-1:0] op, input int count,
                                input int existing, input int page);
        logic [BLK_W-1:0]  cnt;
        logic [BLK_W-1:0]  held;
        logic [PAGE_W-1:0] pid;
        cnt  = BLK_W'(count);
        held = BLK_W'(existing);
        pid  = PAGE_W'(page);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {pid, held, cnt};
        do @(posedge aclk); while (!s_tready);
        pool.take_request(op, cnt, held, pid);
    endtask

    // limit write once the block has drained
    task automatic write_limit(input int value);
        s_tvalid <= 1'b0;
        while (pool.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= BLK_W'(value);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        pool.max_blocks = value & 7'h7f;
    endtask

    // mostly well-formed traffic: frees of held pages, small allocs and appends
    task automatic send_random(output bit counted);
        int pick;
        int lim;
        int cnt;
        pick    = $urandom_range(0, 99);
        lim     = pool.limit();
        counted = 1'b1;
        cnt     = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 8);
        if (pick < 35 && pool.held_pages.size() != 0) begin
            send_request(OP_FREE, $urandom_range(0, 127), $urandom_range(0, 127),
                         pool.held_pages[$urandom_range(0, pool.held_pages.size() - 1)]);
        end else if (pick < 45) begin
            counted = 1'b0;
            send_request(OP_FREE, $urandom_range(0, 127), $urandom_range(0, 127),
                         $urandom_range(0, N_PAGES - 1));
        end else if (pick < 70) begin
            send_request(OP_ALLOC, cnt, 0, $urandom_range(0, N_PAGES - 1));
        end else if (pick < 90) begin
            send_request(OP_APPEND, cnt,
                         ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127)
                                                    : $urandom_range(0, lim),
                         $urandom_range(0, N_PAGES - 1));
        end else if (pick < 95) begin
            send_request(OP_ALLOC, cnt, $urandom_range(1, 127), $urandom_range(0, N_PAGES - 1));
        end else begin
            counted = 1'b0;
            send_request(OP_UNUSED, $urandom_range(0, 127), $urandom_range(0, 127),
                         $urandom_range(0, N_PAGES - 1));
        end
    endtask

    initial begin
        int  done_reqs;
        int  cnt;
        bit  counted;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // edge cases at the reset limit
        write_limit(MAX_BLOCKS_LIMIT);
        send_request(OP_FREE, 127, 127, 0);
        send_request(OP_UNUSED, 0, 0, N_PAGES - 1);
        send_request(OP_ALLOC, 3, 1, 0);
        send_request(OP_ALLOC, 0, 127, 0);
        send_request(OP_ALLOC, 0, 0, 0);
        send_request(OP_APPEND, 0, 127, 0);
        send_request(OP_ALLOC, 65, 0, 0);
        send_request(OP_ALLOC, 127, 0, 0);
        send_request(OP_APPEND, 5, 60, 0);
        send_request(OP_APPEND, 127, 127, 0);
        send_request(OP_ALLOC, 64, 0, 0);
        send_request(OP_APPEND, 1, 63, 0);
        send_request(OP_FREE, 0, 0, 64);
        send_request(OP_FREE, 0, 0, 64);
        send_request(OP_FREE, 0, 0, N_PAGES - 1);
        send_request(OP_ALLOC, 1, 0, 0);

        // zero limit rejects anything non-empty
        write_limit(0);
        send_request(OP_ALLOC, 1, 0, 0);
        send_request(OP_APPEND, 1, 0, 0);
        send_request(OP_ALLOC, 0, 0, 0);
        send_request(OP_APPEND, 0, 5, 0);

        write_limit(1);
        send_request(OP_ALLOC, 1, 0, 0);
        send_request(OP_APPEND, 1, 0, 0);
        send_request(OP_APPEND, 1, 1, 0);

        // limit above range is clamped; drain the whole pool, then ask for more
        write_limit(127);
        while (pool.free_total > 0) begin
            cnt = $urandom_range(1, 64);
            if (pool.free_total < 64 && $urandom_range(0, 1) == 1)
                cnt = pool.free_total;
            send_request(OP_ALLOC, cnt, 0, $urandom_range(0, N_PAGES - 1));
        end
        send_request(OP_ALLOC, 1, 0, 0);
        send_request(OP_APPEND, 1, 0, 0);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_limit(MAX_BLOCKS_LIMIT);
                1: write_limit($urandom_range(2, 8));
                2: write_limit($urandom_range(1, MAX_BLOCKS_LIMIT));
                default: begin
                    write_limit(MAX_BLOCKS_LIMIT);
                    gaps_on = 1'b0;
                end
            endcase
            done_reqs = 0;
            while (done_reqs < PHASE_REQS) begin
                send_random(counted);
                if (counted)
                    done_reqs++;
            end
        end

        s_tvalid <= 1'b0;
        while (pool.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (pool.errors == 0 && pool.pending() == 0)
            $display("fifo_free_list_page_allocator_tb: done, clean");
        else
            $display("fifo_free_list_page_allocator_tb: done, errors");
        $finish;
    end

endmodule
